[sv/jsu_pkg.sv]
// Shared types, codes and helper functions for the JSON string unescaper.
// Used by jsu_decode, jsu_out and json_string_unescape_utf8; no dependencies.
package jsu_pkg;

	// decoder phases
	localparam logic [2:0] PH_NORMAL  = 3'd0;
	localparam logic [2:0] PH_ESCAPE  = 3'd1;
	localparam logic [2:0] PH_HEX1    = 3'd2;
	localparam logic [2:0] PH_WANT_BS = 3'd3;
	localparam logic [2:0] PH_WANT_U  = 3'd4;
	localparam logic [2:0] PH_HEX2    = 3'd5;

	// result status codes
	localparam logic [2:0] ST_CONT    = 3'd0;
	localparam logic [2:0] ST_DONE    = 3'd1;
	localparam logic [2:0] ST_NOQUOTE = 3'd2;
	localparam logic [2:0] ST_BADHEX  = 3'd3;
	localparam logic [2:0] ST_BADSURR = 3'd4;
	localparam logic [2:0] ST_BADESC  = 3'd5;
	localparam logic [2:0] ST_CTRL    = 3'd6;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [15:0] HI_SURR_LO = 16'hD800;
	localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
	localparam logic [15:0] LO_SURR_LO = 16'hDC00;
	localparam logic [15:0] LO_SURR_HI = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [1:0]      last_idx;
	} utf8_t;

	// One burst of results caused by one input byte.
	typedef struct packed {
		logic            valid;     // at least one result
		logic [3:0][7:0] b;         // b[0] goes out first
		logic [1:0]      last_idx;  // number of results minus one
		logic            bv;
		logic [2:0]      status;
	} burst_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h = '0;
		if (c inside {[8'h30:8'h39]}) begin
			h.ok  = 1'b1;
			h.val = c[3:0];
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			h.ok  = 1'b1;
			h.val = 4'(c[2:0] + 3'd1) + 4'd8;
		end
		return h;
	endfunction

	function automatic utf8_t utf8_encode(input logic [20:0] u);
		utf8_t e;
		e = '0;
		if (u <= 21'h7F) begin
			e.b[0]     = u[7:0];
			e.last_idx = 2'd0;
		end else if (u <= 21'h7FF) begin
			e.b[0]     = {3'b110, u[10:6]};
			e.b[1]     = {2'b10, u[5:0]};
			e.last_idx = 2'd1;
		end else if (u <= 21'hFFFF) begin
			e.b[0]     = {4'b1110, u[15:12]};
			e.b[1]     = {2'b10, u[11:6]};
			e.b[2]     = {2'b10, u[5:0]};
			e.last_idx = 2'd2;
		end else begin
			e.b[0]     = {5'b11110, u[20:18]};
			e.b[1]     = {2'b10, u[17:12]};
			e.b[2]     = {2'b10, u[11:6]};
			e.b[3]     = {2'b10, u[5:0]};
			e.last_idx = 2'd3;
		end
		return e;
	endfunction

endpackage

[sv/jsu_decode.sv]
// Escape decoder: phase state and the combinational decode of one byte into a burst.
// Depends on jsu_pkg.
module jsu_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      text_byte,
	input  logic            starts_string,
	input  logic            take,
	output jsu_pkg::burst_t res
);
	import jsu_pkg::*;

	logic [2:0]  phase_q, phase_e, phase_d;
	logic [1:0]  cnt_q, cnt_e, cnt_d;
	logic [15:0] acc_q, acc_e, acc_d;
	logic [9:0]  hs_q, hs_e, hs_d;
	logic        halted_q, halted_e, halted_d;
	hex_t        hv;
	logic [15:0] acc_new;
	logic [20:0] cp_pair;
	utf8_t       enc_a, enc_p;

	always_comb begin
		phase_e  = starts_string ? PH_NORMAL : phase_q;
		cnt_e    = starts_string ? 2'd0 : cnt_q;
		acc_e    = starts_string ? 16'd0 : acc_q;
		hs_e     = starts_string ? 10'd0 : hs_q;
		halted_e = starts_string ? 1'b0 : halted_q;

		hv      = hex_decode(text_byte);
		acc_new = {acc_e[11:0], hv.val};
		cp_pair = {1'b0, hs_e, acc_new[9:0]} + SUPP_BASE;
		enc_a   = utf8_encode({5'd0, acc_new});
		enc_p   = utf8_encode(cp_pair);

		phase_d  = phase_e;
		cnt_d    = cnt_e;
		acc_d    = acc_e;
		hs_d     = hs_e;
		halted_d = halted_e;
		res      = '0;

		if (!halted_e) begin
			res.valid  = 1'b1;
			res.status = ST_CONT;
			case (phase_e)
				PH_NORMAL: begin
					if (text_byte == CH_QUOTE) begin
						res.status = ST_DONE;
					end else if (text_byte == 8'd0) begin
						res.status = ST_NOQUOTE;
					end else if (text_byte == CH_BSL) begin
						phase_d = PH_ESCAPE;
					end else if (text_byte < CH_SPACE) begin
						res.status = ST_CTRL;
					end else begin
						res.b[0] = text_byte;
						res.bv   = 1'b1;
					end
				end
				PH_ESCAPE: begin
					phase_d = PH_NORMAL;
					res.bv  = 1'b1;
					case (text_byte)
						8'h22: res.b[0] = 8'h22;
						8'h5C: res.b[0] = 8'h5C;
						8'h2F: res.b[0] = 8'h2F;
						8'h62: res.b[0] = 8'h08;
						8'h66: res.b[0] = 8'h0C;
						8'h6E: res.b[0] = 8'h0A;
						8'h72: res.b[0] = 8'h0D;
						8'h74: res.b[0] = 8'h09;
						8'h75: begin
							res.bv  = 1'b0;
							phase_d = PH_HEX1;
							cnt_d   = 2'd0;
							acc_d   = 16'd0;
						end
						default: begin
							res.bv     = 1'b0;
							res.status = ST_BADESC;
						end
					endcase
				end
				PH_HEX1, PH_HEX2: begin
					if (!hv.ok) begin
						res.status = ST_BADHEX;
					end else begin
						acc_d = acc_new;
						if (cnt_e != 2'd3) begin
							cnt_d = cnt_e + 2'd1;
						end else begin
							cnt_d = 2'd0;
							if (phase_e == PH_HEX1) begin
								if (acc_new >= HI_SURR_LO && acc_new <= HI_SURR_HI) begin
									hs_d    = acc_new[9:0];
									acc_d   = 16'd0;
									phase_d = PH_WANT_BS;
								end else begin
									phase_d      = PH_NORMAL;
									res.b        = enc_a.b;
									res.last_idx = enc_a.last_idx;
									res.bv       = 1'b1;
								end
							end else if (acc_new < LO_SURR_LO || acc_new > LO_SURR_HI) begin
								res.status = ST_BADSURR;
							end else begin
								phase_d      = PH_NORMAL;
								res.b        = enc_p.b;
								res.last_idx = enc_p.last_idx;
								res.bv       = 1'b1;
							end
						end
					end
				end
				PH_WANT_BS: begin
					if (text_byte != CH_BSL) begin
						res.status = ST_BADSURR;
					end else begin
						phase_d = PH_WANT_U;
					end
				end
				PH_WANT_U: begin
					if (text_byte != 8'h75) begin
						res.status = ST_BADSURR;
					end else begin
						phase_d = PH_HEX2;
						cnt_d   = 2'd0;
						acc_d   = 16'd0;
					end
				end
				default: begin
					// unused codes fall back to plain text
					phase_d = PH_NORMAL;
				end
			endcase
			if (res.status != ST_CONT) begin
				halted_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_NORMAL;
			cnt_q    <= 2'd0;
			acc_q    <= 16'd0;
			hs_q     <= 10'd0;
			halted_q <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			acc_q    <= acc_d;
			hs_q     <= hs_d;
			halted_q <= halted_d;
		end
	end

endmodule

[sv/jsu_out.sv]
// Result register: holds one burst and sends it out one result per transfer.
// Depends on jsu_pkg.
module jsu_out (
	input  logic            clk,
	input  logic            arst_n,
	input  jsu_pkg::burst_t burst,
	input  logic            load,
	output logic            can_load,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,   // out_byte
	output logic [3:0]      m_tuser,   // byte_valid, status[2:0]
	output logic            m_tlast    // last_of_run
);
	import jsu_pkg::*;

	burst_t     burst_q;
	logic       full_q;
	logic [1:0] idx_q;
	logic       at_last;

	assign at_last  = (idx_q == burst_q.last_idx);
	assign can_load = !full_q || (m_tready && at_last);
	assign m_tvalid = full_q;
	assign m_tdata  = burst_q.b[idx_q];
	assign m_tuser  = {burst_q.status, burst_q.bv};
	assign m_tlast  = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (load) begin
			full_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (full_q && m_tready) begin
			if (at_last) begin
				full_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			burst_q <= burst;
		end
	end

	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> idx_q <= burst_q.last_idx)
		else $error("result index past end of burst");

	a_marker_single: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && !burst_q.bv) |-> burst_q.last_idx == 2'd0)
		else $error("non-byte result spans several transfers");

	a_status_on_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && burst_q.bv) |-> burst_q.status == ST_CONT)
		else $error("decoded byte carries an ending status");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_load)
		else $error("burst loaded over one still in flight");

endmodule

[sv/json_string_unescape_utf8.sv]
// Top level of the JSON string unescaper: input register, decoder and result register.
// Depends on jsu_pkg, jsu_decode and jsu_out.
//
//  channel | direction | tdata        | tuser                 | tlast
//  s_*     | in        | text_byte    | starts_string         | -
//  m_*     | out       | out_byte     | byte_valid, status    | last_of_run
//
// A byte that decodes to one result (or none) moves through at one byte per cycle unless
// m_tready stalls; a \uXXXX escape that ends in an N-byte UTF-8 sequence holds the result
// register until its N bytes are sent, while one further byte waits in the input register.
// arst_n clears the decoder to plain-text phase and empties both registers. A stalled
// m_tready holds the result and backs up s_tready.
module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // text_byte
	input  logic       s_tuser,   // starts_string
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic [3:0] m_tuser,   // byte_valid, status[2:0]
	output logic       m_tlast    // last_of_run
);
	import jsu_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	burst_t     res;
	logic       can_load;
	logic       advance;

	// a halted byte yields nothing and needs no room downstream
	assign advance  = valid_s1 && (!res.valid || can_load);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	jsu_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_byte    (byte_s1),
		.starts_string(start_s1),
		.take         (advance),
		.res          (res)
	);

	jsu_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.burst    (res),
		.load     (advance && res.valid),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
